[src/lfid_pkg.sv]
// shared constants and types for the lowest free identifier allocator
package lfid_pkg;

  // table size defaults
  localparam int MAX_IDS_DEF  = 256;
  localparam int FIRST_ID_DEF = 2;

  // identifiers are 8 bits wide, so only this many slots are usable
  localparam int IDENT_SPAN = 256;

  // field widths
  localparam int OWNER_W  = 16;
  localparam int IDENT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;
  localparam int M_PAD_W  = M_DATA_W - IDENT_W - STATUS_W;

  // command codes
  typedef enum logic {
    CMD_ALLOCATE = 1'b0,
    CMD_RELEASE  = 1'b1
  } command_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

[src/lowest_free_id_allocator.sv]
// identifier allocator: owner tags in a synchronous memory, valid bits in flops
// sequence: a command scans the slots upward from FIRST_ID, reading each tag and valid bit,
// and ends at the first hit; a miss scans every usable slot up to USED_IDS - 1
// throughput: one command at a time, bounded by the slot scan (one slot per cycle through
// the single read port of the owner memory); the next accept can come as the result shows
// reset: rst clears every valid bit at once, so the table starts empty with no clearing pass
module lowest_free_id_allocator #(
  parameter int MAX_IDS  = lfid_pkg::MAX_IDS_DEF,
  parameter int FIRST_ID = lfid_pkg::FIRST_ID_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lfid_pkg::S_DATA_W-1:0] s_tdata,   // [15:0] owner
  input  logic [0:0]                    s_tuser,   // [0] command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lfid_pkg::M_DATA_W-1:0] m_tdata    // [7:0] ident, [9:8] status, rest zero
);
  import lfid_pkg::*;

  localparam int USED_IDS = (MAX_IDS < IDENT_SPAN) ? MAX_IDS : IDENT_SPAN;
  localparam int IW       = $clog2(USED_IDS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(USED_IDS - 1);
  localparam logic [IW-1:0] FIRST_IDX = IW'(FIRST_ID);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  logic                cmd_reg;
  logic [OWNER_W-1:0]  tag_reg;
  logic [IW-1:0]       scan_idx;
  logic                issue_on;
  logic                p_on;
  logic [IW-1:0]       p_idx;
  logic                p_vbit;
  logic [IW-1:0]       res_idx;
  status_t             res_status;
  logic [USED_IDS-1:0] slot_valid;
  logic [OWNER_W-1:0]  owner_mem [USED_IDS];
  logic [OWNER_W-1:0]  owner_rd;
  logic                hit;
  logic                out_free;
  logic                wr_owner;
  logic [IDENT_W-1:0]  res_ident;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign wr_owner = (state == S_FINISH) && out_free && (res_status == ST_ALLOCATED);

  // hit test on the slot whose tag arrives from memory this cycle
  always_comb begin
    if (cmd_reg == CMD_ALLOCATE) begin
      hit = !p_vbit;
    end else begin
      hit = p_vbit && (owner_rd == tag_reg);
    end
  end

  // a miss reports identifier 0
  assign res_ident = (res_status == ST_ALLOCATED || res_status == ST_RELEASED) ?
                     IDENT_W'(res_idx) : '0;

  // owner tag memory, one read and one write port
  always_ff @(posedge clk) begin
    owner_rd <= owner_mem[scan_idx];
    if (wr_owner) begin
      owner_mem[res_idx] <= tag_reg;
    end
  end

  // command sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_on   <= 1'b0;
      p_on       <= 1'b0;
      m_tvalid   <= 1'b0;
      slot_valid <= '0;
    end else begin
      // the finish step reloads the output register itself
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          p_on <= 1'b0;
          if (s_tvalid) begin
            cmd_reg  <= s_tuser[0];
            tag_reg  <= s_tdata[OWNER_W-1:0];
            scan_idx <= FIRST_IDX;
            issue_on <= 1'b1;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue the next slot read alongside its valid bit
          p_on   <= issue_on;
          p_idx  <= scan_idx;
          p_vbit <= slot_valid[scan_idx];
          if (issue_on) begin
            if (scan_idx == LAST_IDX) begin
              issue_on <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          // check the slot read in the previous cycle
          if (p_on) begin
            if (hit) begin
              res_idx    <= p_idx;
              res_status <= (cmd_reg == CMD_ALLOCATE) ? ST_ALLOCATED : ST_RELEASED;
              issue_on   <= 1'b0;
              state      <= S_FINISH;
            end else if (p_idx == LAST_IDX) begin
              res_idx    <= p_idx;
              res_status <= (cmd_reg == CMD_ALLOCATE) ? ST_FULL : ST_NOT_FOUND;
              issue_on   <= 1'b0;
              state      <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          p_on <= 1'b0;
          // commit the table change once the output register is free
          if (out_free) begin
            if (res_status == ST_ALLOCATED) begin
              slot_valid[res_idx] <= 1'b1;
            end else if (res_status == ST_RELEASED) begin
              slot_valid[res_idx] <= 1'b0;
            end
            m_tvalid <= 1'b1;
            m_tdata  <= {{M_PAD_W{1'b0}}, res_status, res_ident};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/lfid_checker.sv]
// port-level checks for the lowest free identifier allocator, bound to the top level
module lfid_checker #(
  parameter int FIRST_ID = lfid_pkg::FIRST_ID_DEF,
  parameter int USED_IDS = lfid_pkg::IDENT_SPAN
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lfid_pkg::M_DATA_W-1:0] m_tdata
);
  import lfid_pkg::*;

  logic [IDENT_W-1:0]  ident;
  logic [STATUS_W-1:0] status;

  assign ident  = m_tdata[IDENT_W-1:0];
  assign status = m_tdata[IDENT_W+STATUS_W-1:IDENT_W];

  // one command at a time: no new item right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while a command is still in work");

  // a successful result names a usable identifier
  a_ident_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_ALLOCATED || status == ST_RELEASED) |->
      (32'(ident) >= FIRST_ID) && (32'(ident) < USED_IDS))
    else $error("identifier outside the usable range");

  // a miss reports identifier zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_FULL || status == ST_NOT_FOUND) |-> ident == '0)
    else $error("miss result carries a nonzero identifier");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind lowest_free_id_allocator lfid_checker #(
  .FIRST_ID(FIRST_ID),
  .USED_IDS(USED_IDS)
) u_lfid_checker (.*);
